// File: rtl/lavm_pkg.sv
// ----------------------------------------------------------------------------
// lavm_pkg
// Shared types and constants of the look-at view matrix generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lavm_pkg;

  localparam int unsigned FifoDepthDef = 2;
  localparam int unsigned NumEntries   = 16;
  localparam logic signed [31:0] QOne  = 32'sh0001_0000;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [63:0] wide_t;
  typedef logic signed [65:0] dsum_t;

  typedef struct packed {
    coord_t [2:0] eye;
    diff_t  [2:0] fwd;
    coord_t [2:0] up;
    logic         fwd_zero;
    logic         up_zero;
  } item_t;

  typedef struct packed {
    coord_t [2:0] s;
    coord_t [2:0] u;
    coord_t [2:0] f;
    dsum_t  [2:0] d;
  } mat_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_MAG,
    E_NORM,
    E_SQ,
    E_SQRT,
    E_DIVI,
    E_DIV,
    E_RET,
    E_CROSS,
    E_UROUND,
    E_DOT,
    E_DONE
  } eng_state_e;

  typedef enum logic [1:0] {
    PH_FWD,
    PH_UP,
    PH_SIDE
  } phase_e;

  typedef enum logic {
    CR_SIDE,
    CR_TRUE_UP
  } cross_e;

endpackage

`default_nettype wire

// File: rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at view matrix generator in signed Q16.16, one matrix per command.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  command   | start, busy            | eye_*_i, target_*_i, up_*_i
//  entry     | entry_valid_o (strobe) | entry_index_o, entry_value_o,
//            |                        | last_entry_o
//
//  A command is transferred when start is high and busy is low.
//  The engine's work per command is set by its sequencer: three
//  normalizations, each with a one-bit-per-cycle range shift, a 32-step
//  square root and 31-step dividers, plus 30 products on one shared 32x32
//  multiplier. A zero-length vector skips its normalization, and all three
//  are skipped when forward and up are both zero. The sixteen entries then
//  follow on consecutive cycles while the engine already works on the next command.
//  Reset clears the queue, the sequencer and the output strobe.
//  The entry receiver cannot stall; busy is high only while the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix
  import lavm_pkg::*;
#(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  coord_t     eye_x_i,
  input  coord_t     eye_y_i,
  input  coord_t     eye_z_i,
  input  coord_t     target_x_i,
  input  coord_t     target_y_i,
  input  coord_t     target_z_i,
  input  coord_t     up_x_i,
  input  coord_t     up_y_i,
  input  coord_t     up_z_i,
  output logic       entry_valid_o,
  output logic [3:0] entry_index_o,
  output coord_t     entry_value_o,
  output logic       last_entry_o
);

  logic  full, push, item_valid, item_pop, mat_valid, mat_ready;
  item_t item_in, item_out;
  mat_t  mat;

  lavm_front u_front (
    .start      (start),
    .busy       (busy),
    .eye_x_i    (eye_x_i),
    .eye_y_i    (eye_y_i),
    .eye_z_i    (eye_z_i),
    .target_x_i (target_x_i),
    .target_y_i (target_y_i),
    .target_z_i (target_z_i),
    .up_x_i     (up_x_i),
    .up_y_i     (up_y_i),
    .up_z_i     (up_z_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (item_in)
  );

  lavm_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_in),
    .full_o  (full),
    .pop_i   (item_pop),
    .valid_o (item_valid),
    .data_o  (item_out)
  );

  lavm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item_out),
    .item_pop_o   (item_pop),
    .mat_valid_o  (mat_valid),
    .mat_ready_i  (mat_ready),
    .mat_o        (mat)
  );

  lavm_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mat_valid_i   (mat_valid),
    .mat_ready_o   (mat_ready),
    .mat_i         (mat),
    .entry_valid_o (entry_valid_o),
    .entry_index_o (entry_index_o),
    .entry_value_o (entry_value_o),
    .last_entry_o  (last_entry_o)
  );

endmodule

`default_nettype wire

// File: rtl/lavm_front.sv
// ----------------------------------------------------------------------------
// lavm_front
// Command intake: forms the forward vector and flags zero-length inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_front
  import lavm_pkg::*;
(
  input  logic   start,
  output logic   busy,
  input  coord_t eye_x_i,
  input  coord_t eye_y_i,
  input  coord_t eye_z_i,
  input  coord_t target_x_i,
  input  coord_t target_y_i,
  input  coord_t target_z_i,
  input  coord_t up_x_i,
  input  coord_t up_y_i,
  input  coord_t up_z_i,
  input  logic   full_i,
  output logic   push_o,
  output item_t  item_o
);

  coord_t eye [3];
  coord_t tgt [3];
  coord_t upv [3];

  assign eye[0] = eye_x_i;
  assign eye[1] = eye_y_i;
  assign eye[2] = eye_z_i;
  assign tgt[0] = target_x_i;
  assign tgt[1] = target_y_i;
  assign tgt[2] = target_z_i;
  assign upv[0] = up_x_i;
  assign upv[1] = up_y_i;
  assign upv[2] = up_z_i;

  assign busy   = full_i;
  assign push_o = start && !full_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item_o.eye[i] = eye[i];
      item_o.up[i]  = upv[i];
      item_o.fwd[i] = {tgt[i][31], tgt[i]} - {eye[i][31], eye[i]};
    end
    item_o.fwd_zero = (eye[0] == tgt[0]) && (eye[1] == tgt[1]) && (eye[2] == tgt[2]);
    item_o.up_zero  = (upv[0] == '0) && (upv[1] == '0) && (upv[2] == '0);
  end

endmodule

`default_nettype wire

// File: rtl/lavm_fifo.sv
// ----------------------------------------------------------------------------
// lavm_fifo
// Short command queue between the intake and the matrix engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_fifo
  import lavm_pkg::*;
#(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/lavm_engine.sv
// ----------------------------------------------------------------------------
// lavm_engine
// Sequencer that normalizes, crosses and projects the camera vectors with one
// shared multiplier, a bit-serial square root and three serial dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_engine
  import lavm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  item_pop_o,
  output logic  mat_valid_o,
  input  logic  mat_ready_i,
  output mat_t  mat_o
);

  eng_state_e  state_q, state_d;
  phase_e      phase_q;
  cross_e      cross_q;
  logic [4:0]  cnt_q;
  logic        up_zero_q;
  coord_t      eye_q    [3];
  coord_t      up_raw_q [3];
  wide_t       vsrc_q   [3];
  logic [63:0] mag_q    [3];
  coord_t      f_q      [3];
  coord_t      up_q     [3];
  coord_t      s_q      [3];
  coord_t      u_q      [3];
  dsum_t       acc_q;
  wide_t       prod_q;
  logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
  logic [31:0] rem_q    [3];
  logic [30:0] dlo_q    [3];
  logic [30:0] quo_q    [3];
  dsum_t       dsum_q   [3];
  logic [1:0]  pj_q, pc_q;

  coord_t      op_a, op_b;
  wide_t       prod_d;
  coord_t      va [3];
  coord_t      vb [3];
  coord_t      res_vec [3];
  logic [63:0] mag_or;
  logic        norm_hi, norm_lo, vsrc_zero;
  logic [1:0]  dj, dc;
  dsum_t       prod_ext, dot_sum;
  logic [63:0] sq_t;

  function automatic coord_t pick(coord_t a0, coord_t a1, coord_t a2, logic [1:0] k);
    coord_t r;
    unique case (k)
      2'd0:    r = a0;
      2'd1:    r = a1;
      default: r = a2;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] abs64(wide_t v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic coord_t rnd30(wide_t v);
    logic [63:0] m;
    m = (abs64(v) + (64'd1 << 29)) >> 30;
    return v[63] ? (32'd0 - m[31:0]) : m[31:0];
  endfunction

  function automatic wide_t ext_up(coord_t v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic wide_t ext_fwd(diff_t v);
    return {{31{v[32]}}, v};
  endfunction

  assign mag_or    = mag_q[0] | mag_q[1] | mag_q[2];
  assign norm_hi   = |mag_or[63:31];
  assign norm_lo   = ~mag_or[30];
  assign vsrc_zero = (vsrc_q[0] == '0) && (vsrc_q[1] == '0) && (vsrc_q[2] == '0);
  assign prod_ext  = {{2{prod_q[63]}}, prod_q};
  assign dot_sum   = (pc_q == 2'd0) ? prod_ext : acc_q + prod_ext;
  assign sq_t      = sq_res_q + sq_bit_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i]      = (cross_q == CR_SIDE) ? f_q[i]  : s_q[i];
      vb[i]      = (cross_q == CR_SIDE) ? up_q[i] : f_q[i];
      res_vec[i] = vsrc_q[i][63] ? (32'd0 - {1'b0, quo_q[i]}) : {1'b0, quo_q[i]};
    end
    if (cnt_q < 5'd3) begin
      dj = 2'd0;
      dc = cnt_q[1:0];
    end else if (cnt_q < 5'd6) begin
      dj = 2'd1;
      dc = 2'(cnt_q - 5'd3);
    end else begin
      dj = 2'd2;
      dc = 2'(cnt_q - 5'd6);
    end
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_q)
      E_SQ: begin
        op_a = pick(mag_q[0][31:0], mag_q[1][31:0], mag_q[2][31:0], cnt_q[1:0]);
        op_b = op_a;
      end
      E_CROSS: begin
        unique case (cnt_q)
          5'd0: begin op_a = va[1]; op_b = vb[2]; end
          5'd1: begin op_a = va[2]; op_b = vb[1]; end
          5'd2: begin op_a = va[2]; op_b = vb[0]; end
          5'd3: begin op_a = va[0]; op_b = vb[2]; end
          5'd4: begin op_a = va[0]; op_b = vb[1]; end
          5'd5: begin op_a = va[1]; op_b = vb[0]; end
          default: begin op_a = '0; op_b = '0; end
        endcase
      end
      E_DOT: begin
        unique case (dj)
          2'd0:    op_a = pick(s_q[0], s_q[1], s_q[2], dc);
          2'd1:    op_a = pick(u_q[0], u_q[1], u_q[2], dc);
          default: op_a = pick(f_q[0], f_q[1], f_q[2], dc);
        endcase
        op_b = pick(eye_q[0], eye_q[1], eye_q[2], dc);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    item_pop_o  = 1'b0;
    mat_valid_o = 1'b0;
    unique case (state_q)
      E_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          state_d    = (item_i.fwd_zero && item_i.up_zero) ? E_CROSS : E_MAG;
        end
      end
      E_MAG:    state_d = vsrc_zero ? E_RET : E_NORM;
      E_NORM:   state_d = (!norm_hi && !norm_lo) ? E_SQ : E_NORM;
      E_SQ:     state_d = (cnt_q == 5'd3) ? E_SQRT : E_SQ;
      E_SQRT:   state_d = (cnt_q == 5'd31) ? E_DIVI : E_SQRT;
      E_DIVI:   state_d = E_DIV;
      E_DIV:    state_d = (cnt_q == 5'd30) ? E_RET : E_DIV;
      E_RET: begin
        if (phase_q == PH_FWD && !up_zero_q) begin
          state_d = E_MAG;
        end else begin
          state_d = E_CROSS;
        end
      end
      E_CROSS: begin
        if (cnt_q == 5'd6) begin
          state_d = (cross_q == CR_SIDE) ? E_MAG : E_UROUND;
        end
      end
      E_UROUND: state_d = E_DOT;
      E_DOT:    state_d = (cnt_q == 5'd9) ? E_DONE : E_DOT;
      E_DONE: begin
        mat_valid_o = 1'b1;
        if (mat_ready_i) begin
          state_d = E_IDLE;
        end
      end
      default:  state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      E_IDLE: begin
        if (item_valid_i) begin
          up_zero_q <= item_i.up_zero;
          cross_q   <= CR_SIDE;
          cnt_q     <= '0;
          for (int i = 0; i < 3; i++) begin
            eye_q[i]    <= item_i.eye[i];
            up_raw_q[i] <= item_i.up[i];
          end
          if (!item_i.fwd_zero) begin
            phase_q <= PH_FWD;
            for (int i = 0; i < 3; i++) vsrc_q[i] <= ext_fwd(item_i.fwd[i]);
          end else begin
            phase_q <= PH_UP;
            for (int i = 0; i < 3; i++) begin
              f_q[i]    <= '0;
              up_q[i]   <= '0;
              vsrc_q[i] <= ext_up(item_i.up[i]);
            end
          end
        end
      end
      E_MAG: begin
        for (int i = 0; i < 3; i++) begin
          mag_q[i] <= abs64(vsrc_q[i]);
          quo_q[i] <= '0;
        end
      end
      E_NORM: begin
        if (norm_hi) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end else if (norm_lo) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
        end else begin
          acc_q <= '0;
          cnt_q <= '0;
        end
      end
      E_SQ: begin
        if (cnt_q != 5'd0) begin
          acc_q <= acc_q + prod_ext;
        end
        if (cnt_q == 5'd3) begin
          sq_n_q   <= acc_q[63:0] + prod_q;
          sq_res_q <= '0;
          sq_bit_q <= 64'd1 << 62;
          cnt_q    <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      E_SQRT: begin
        if (sq_n_q >= sq_t) begin
          sq_n_q   <= sq_n_q - sq_t;
          sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
        cnt_q    <= cnt_q + 1'b1;
      end
      E_DIVI: begin
        for (int i = 0; i < 3; i++) begin
          logic [61:0] dd;
          dd       = {1'b0, mag_q[i][30:0], 30'd0} + {31'd0, sq_res_q[31:1]};
          rem_q[i] <= {1'b0, dd[61:31]};
          dlo_q[i] <= dd[30:0];
          quo_q[i] <= '0;
        end
        cnt_q <= '0;
      end
      E_DIV: begin
        for (int i = 0; i < 3; i++) begin
          logic [32:0] r2;
          logic        ge;
          r2       = {rem_q[i], dlo_q[i][30]};
          ge       = (r2 >= {1'b0, sq_res_q[31:0]});
          rem_q[i] <= ge ? 32'(r2 - {1'b0, sq_res_q[31:0]}) : r2[31:0];
          quo_q[i] <= {quo_q[i][29:0], ge};
          dlo_q[i] <= {dlo_q[i][29:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
      end
      E_RET: begin
        cnt_q <= '0;
        unique case (phase_q)
          PH_FWD: begin
            for (int i = 0; i < 3; i++) f_q[i] <= res_vec[i];
            if (up_zero_q) begin
              for (int i = 0; i < 3; i++) up_q[i] <= '0;
              cross_q <= CR_SIDE;
            end else begin
              phase_q <= PH_UP;
              for (int i = 0; i < 3; i++) vsrc_q[i] <= ext_up(up_raw_q[i]);
            end
          end
          PH_UP: begin
            for (int i = 0; i < 3; i++) up_q[i] <= res_vec[i];
            cross_q <= CR_SIDE;
          end
          default: begin
            for (int i = 0; i < 3; i++) s_q[i] <= res_vec[i];
            cross_q <= CR_TRUE_UP;
          end
        endcase
      end
      E_CROSS: begin
        unique case (cnt_q)
          5'd1, 5'd3, 5'd5: acc_q <= prod_ext;
          5'd2: vsrc_q[0] <= acc_q[63:0] - prod_q;
          5'd4: vsrc_q[1] <= acc_q[63:0] - prod_q;
          5'd6: vsrc_q[2] <= acc_q[63:0] - prod_q;
          default: acc_q <= acc_q;
        endcase
        if (cnt_q == 5'd6) begin
          phase_q <= PH_SIDE;
          cnt_q   <= '0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      E_UROUND: begin
        for (int i = 0; i < 3; i++) u_q[i] <= rnd30(vsrc_q[i]);
        cnt_q <= '0;
      end
      E_DOT: begin
        if (cnt_q < 5'd9) begin
          pj_q <= dj;
          pc_q <= dc;
        end
        if (cnt_q != 5'd0) begin
          acc_q <= dot_sum;
          if (pc_q == 2'd2) begin
            unique case (pj_q)
              2'd0:    dsum_q[0] <= dot_sum;
              2'd1:    dsum_q[1] <= dot_sum;
              default: dsum_q[2] <= dot_sum;
            endcase
          end
        end
        cnt_q <= cnt_q + 1'b1;
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mat_o.s[i] = s_q[i];
      mat_o.u[i] = u_q[i];
      mat_o.f[i] = f_q[i];
      mat_o.d[i] = dsum_q[i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lavm_emit.sv
// ----------------------------------------------------------------------------
// lavm_emit
// Holds one finished matrix and sends its sixteen entries in index order.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_emit
  import lavm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mat_valid_i,
  output logic       mat_ready_o,
  input  mat_t       mat_i,
  output logic       entry_valid_o,
  output logic [3:0] entry_index_o,
  output coord_t     entry_value_o,
  output logic       last_entry_o
);

  mat_t       mat_q;
  logic       act_q;
  logic [3:0] idx_q;
  logic       take;
  coord_t     val;

  function automatic coord_t rot16(coord_t x, logic neg);
    logic [31:0] mg;
    logic [32:0] m;
    mg = x[31] ? (32'd0 - x) : x;
    m  = ({1'b0, mg} + 33'd8192) >> 14;
    return (x[31] ^ neg) ? (32'd0 - m[31:0]) : m[31:0];
  endfunction

  function automatic coord_t trans16(dsum_t d, logic neg);
    logic [65:0] mg;
    logic [65:0] m;
    coord_t      r;
    mg = d[65] ? (66'd0 - d) : d;
    m  = (mg + (66'd1 << 29)) >> 30;
    if (d[65] ^ neg) begin
      r = (m > 66'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end else begin
      r = (m > 66'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  assign mat_ready_o = !act_q || (idx_q == 4'(NumEntries - 1));
  assign take        = mat_valid_i && mat_ready_o;

  always_comb begin
    val = '0;
    unique case (idx_q[3:2])
      2'd3: begin
        unique case (idx_q[1:0])
          2'd0:    val = trans16(mat_q.d[0], 1'b1);
          2'd1:    val = trans16(mat_q.d[1], 1'b1);
          2'd2:    val = trans16(mat_q.d[2], 1'b0);
          default: val = QOne;
        endcase
      end
      default: begin
        unique case (idx_q[1:0])
          2'd0:    val = rot16(mat_q.s[idx_q[3:2]], 1'b0);
          2'd1:    val = rot16(mat_q.u[idx_q[3:2]], 1'b0);
          2'd2:    val = rot16(mat_q.f[idx_q[3:2]], 1'b1);
          default: val = '0;
        endcase
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mat_q <= mat_i;
    end
    entry_index_o <= idx_q;
    entry_value_o <= val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q         <= 1'b0;
      idx_q         <= '0;
      entry_valid_o <= 1'b0;
      last_entry_o  <= 1'b0;
    end else begin
      entry_valid_o <= act_q;
      last_entry_o  <= act_q && (idx_q == 4'(NumEntries - 1));
      if (take) begin
        act_q <= 1'b1;
        idx_q <= '0;
      end else if (act_q) begin
        idx_q <= idx_q + 1'b1;
        if (idx_q == 4'(NumEntries - 1)) begin
          act_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/lavm_checker.sv
// ----------------------------------------------------------------------------
// lavm_checker
// Port-level checks on the entry stream of the view matrix generator.
// ----------------------------------------------------------------------------
`default_nettype none

module lavm_checker
  import lavm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       entry_valid_o,
  input logic [3:0] entry_index_o,
  input coord_t     entry_value_o,
  input logic       last_entry_o
);

  a_last_on_fifteen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_o |-> (last_entry_o == (entry_index_o == 4'd15)))
    else $error("last entry flag does not match entry fifteen");

  a_index_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_valid_o && entry_index_o != 4'd15) |=>
      (entry_valid_o && entry_index_o == $past(entry_index_o) + 4'd1))
    else $error("entry transfers of one matrix are not consecutive");

  a_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_valid_o && !$past(entry_valid_o)) |-> (entry_index_o == 4'd0))
    else $error("matrix does not start at entry zero");

  a_const_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_valid_o && (entry_index_o == 4'd3 || entry_index_o == 4'd7 ||
                       entry_index_o == 4'd11)) |-> (entry_value_o == '0))
    else $error("bottom row entry is not zero");

  a_one_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_valid_o && entry_index_o == 4'd15) |-> (entry_value_o == QOne))
    else $error("entry fifteen is not one");

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (.*);

`default_nettype wire
